@@ rtl/avss_pkg.sv @@
// shared types, constants and the segment lookup for the voltage readout shifter
// no dependencies; imported by every module of the block
package avss_pkg;

	localparam int DIGIT_COUNT     = 4;
	localparam int SEG_W           = 8;
	localparam int SAMPLE_W        = 10;
	localparam int SCALE_W         = 16;
	localparam int PROD_W          = SAMPLE_W + SCALE_W;
	localparam int RAW_W           = PROD_W - SCALE_W;
	localparam int VALUE_W         = 9;
	localparam int DIGIT_W         = 4;
	localparam int FRAME_BITS      = 16;
	localparam int ITEM_BITS       = DIGIT_COUNT * FRAME_BITS;
	localparam int BIT_CNT_W       = $clog2(ITEM_BITS);
	localparam int BIT_IDX_W       = $clog2(FRAME_BITS);
	localparam int SLOT_W          = $clog2(DIGIT_COUNT);
	localparam int CFG_IDX_W       = 1;
	localparam int CFG_DATA_W      = 16;
	localparam int QUEUE_DEPTH_DEF = 4;

	// reciprocal multiplies for /100 and /10, exact for values up to 499
	localparam int Q100_W   = 15;
	localparam int Q10_W    = 17;
	localparam int RECIP100 = 41;
	localparam int SHIFT100 = 12;
	localparam int RECIP10  = 205;
	localparam int SHIFT10  = 11;

	localparam logic [VALUE_W-1:0]    VALUE_MAX    = 9'd499;
	localparam logic [SCALE_W-1:0]    SCALE_RESET  = 16'd31999;
	localparam logic [SEG_W-1:0]      SEP_RESET    = 8'hBF;
	localparam logic [SEG_W-1:0]      SELECT_FIRST = 8'h08;

	localparam logic [CFG_IDX_W-1:0]  REG_SCALE = 1'b0;
	localparam logic [CFG_IDX_W-1:0]  REG_SEP   = 1'b1;

	typedef struct packed {
		logic [DIGIT_COUNT-1:0][SEG_W-1:0] seg;
	} frame_set_t;

	// common-anode segment codes
	function automatic logic [SEG_W-1:0] seg_of(input logic [DIGIT_W-1:0] digit);
		logic [SEG_W-1:0] code;
		unique case (digit)
			4'd0: code = 8'hC0;
			4'd1: code = 8'hF9;
			4'd2: code = 8'hA4;
			4'd3: code = 8'hB0;
			4'd4: code = 8'h99;
			4'd5: code = 8'h92;
			4'd6: code = 8'h82;
			4'd7: code = 8'hF8;
			4'd8: code = 8'h80;
			4'd9: code = 8'h90;
			default: code = 8'hFF;
		endcase
		return code;
	endfunction

endpackage

@@ rtl/avss_front.sv @@
// front end: config registers, sample scaling, digit split and segment lookup
// depends on avss_pkg; pushes one frame set per item into avss_queue
module avss_front #(
	parameter int QUEUE_DEPTH = avss_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [avss_pkg::SAMPLE_W-1:0]       sample,
	input  logic                                cfg_we,
	input  logic [avss_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [avss_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [$clog2(QUEUE_DEPTH+1)-1:0]    q_count,
	output logic                                busy,
	output logic                                push,
	output avss_pkg::frame_set_t                push_data
);
	import avss_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic [SCALE_W-1:0] scale_q;
	logic [SEG_W-1:0]   sep_q;

	logic               v_s1;
	logic [PROD_W-1:0]  prod_s1;
	logic               v_s2;
	frame_set_t         frame_s2;

	logic [RAW_W-1:0]   value_raw;
	logic [VALUE_W-1:0] value;
	logic [Q100_W-1:0]  q100;
	logic [Q10_W-1:0]   q10;
	logic [DIGIT_W-1:0] hundreds;
	logic [DIGIT_W-1:0] tens;
	logic [DIGIT_W-1:0] units;
	logic [VALUE_W-1:0] tenfold;
	logic [VALUE_W-1:0] hundreds_x10;
	frame_set_t         frame_d;
	logic [CW:0]        occupancy;
	logic               accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_RESET;
			sep_q   <= SEP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCALE: scale_q <= cfg_data[SCALE_W-1:0];
				REG_SEP:   sep_q   <= cfg_data[SEG_W-1:0];
			endcase
		end
	end

	// items in flight hold a queue slot each, so the pipeline never stalls
	assign occupancy = (CW+1)'(q_count) + (CW+1)'(v_s1) + (CW+1)'(v_s2);
	assign busy      = occupancy >= (CW+1)'(QUEUE_DEPTH);
	assign accept    = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1  <= PROD_W'(sample) * PROD_W'(scale_q);
		frame_s2 <= frame_d;
	end

	always_comb begin
		value_raw    = prod_s1[PROD_W-1:SCALE_W];
		value        = (value_raw > RAW_W'(VALUE_MAX)) ? VALUE_MAX : value_raw[VALUE_W-1:0];
		q100         = (Q100_W'(value) * Q100_W'(RECIP100)) >> SHIFT100;
		q10          = (Q10_W'(value) * Q10_W'(RECIP10)) >> SHIFT10;
		hundreds     = q100[DIGIT_W-1:0];
		hundreds_x10 = VALUE_W'(hundreds) * VALUE_W'(10);
		tenfold      = VALUE_W'(q10) * VALUE_W'(10);
		tens         = DIGIT_W'(VALUE_W'(q10) - hundreds_x10);
		units        = DIGIT_W'(value - tenfold);
		frame_d.seg[0] = seg_of(hundreds);
		frame_d.seg[1] = sep_q;
		frame_d.seg[2] = seg_of(tens);
		frame_d.seg[3] = seg_of(units);
	end

	assign push      = v_s2;
	assign push_data = frame_s2;

endmodule

@@ rtl/avss_queue.sv @@
// small register queue of frame sets between front and back ends
// depends on avss_pkg
module avss_queue #(
	parameter int QUEUE_DEPTH = avss_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	input  avss_pkg::frame_set_t                push_data,
	input  logic                                pop,
	output avss_pkg::frame_set_t                head,
	output logic                                not_empty,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0]    count
);
	import avss_pkg::*;

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	frame_set_t      entry_q [QUEUE_DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head      = entry_q[rd_ptr_q];
	assign not_empty = count_q != '0;
	assign count     = count_q;

endmodule

@@ rtl/avss_back.sv @@
// back end: serializes four 16-bit frames per item, one bit per cycle
// depends on avss_pkg; pulls frame sets from avss_queue
module avss_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_valid,
	input  avss_pkg::frame_set_t                head,
	output logic                                pop,
	output logic                                strobe,
	output logic                                serial_bit,
	output logic                                latch_after,
	output logic [avss_pkg::SLOT_W-1:0]         digit_slot,
	output logic                                last
);
	import avss_pkg::*;

	localparam logic [BIT_CNT_W-1:0] LAST_CNT = BIT_CNT_W'(ITEM_BITS - 1);
	localparam logic [BIT_IDX_W-1:0] LAST_BIT = BIT_IDX_W'(FRAME_BITS - 1);

	frame_set_t            cur_q;
	logic                  active_q;
	logic [BIT_CNT_W-1:0]  cnt_q;
	logic                  strobe_q;
	logic                  bit_q;
	logic                  latch_q;
	logic [SLOT_W-1:0]     slot_q;
	logic                  last_q;

	logic [SLOT_W-1:0]     slot;
	logic [BIT_IDX_W-1:0]  bit_idx;
	logic [FRAME_BITS-1:0] frame;
	logic                  item_end;

	assign slot     = cnt_q[BIT_CNT_W-1:BIT_IDX_W];
	assign bit_idx  = cnt_q[BIT_IDX_W-1:0];
	assign frame    = {cur_q.seg[slot], SELECT_FIRST >> slot};
	assign item_end = cnt_q == LAST_CNT;

	// take the next item on the last bit of the current one, no gap
	assign pop = q_valid && (!active_q || item_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= active_q;
			if (pop) begin
				active_q <= 1'b1;
				cnt_q    <= '0;
			end else if (active_q) begin
				active_q <= !item_end;
				cnt_q    <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		bit_q   <= frame[LAST_BIT - bit_idx];
		latch_q <= bit_idx == LAST_BIT;
		slot_q  <= slot;
		last_q  <= item_end;
	end

	assign strobe      = strobe_q;
	assign serial_bit  = bit_q;
	assign latch_after = latch_q;
	assign digit_slot  = slot_q;
	assign last        = last_q;

endmodule

@@ rtl/adc_voltage_seven_segment_shifter.sv @@
// Voltage readout shifter for a four-digit seven-segment display behind
// two cascaded 8-bit shift registers.
//
// Use: raise start with a 10-bit sample; it is taken at a clock edge where
// busy is low. Each item yields 64 results, one per cycle, each marked by a
// one-cycle strobe: serial_bit (MSB first), latch_after on the sixteenth
// bit of each frame, digit_slot of the frame, and last on the final bit.
// Frames: units digit, separator, tenths digit, hundredths digit.
// A sample's first bit strobes after the product and frame registers, the
// queue, and the serializer's item and output registers. Bits go out one per
// cycle; frames of consecutive queued items follow with no gap. The front
// end scales and converts in two stages and parks up to QUEUE_DEPTH items in
// a queue; busy rises once queued items plus those in both stages fill it.
// Config: cfg_we/cfg_index/cfg_data write scale_factor (0) and
// separator_pattern (1); write them only while no item is pending.
// Reset: config returns to 31999 and a dash, queue and serializer empty.
// Results cannot be held off by the receiver.
module adc_voltage_seven_segment_shifter #(
	parameter int QUEUE_DEPTH = avss_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [avss_pkg::SAMPLE_W-1:0]       sample,
	input  logic                                cfg_we,
	input  logic [avss_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [avss_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic                                strobe,
	output logic                                serial_bit,
	output logic                                latch_after,
	output logic [avss_pkg::SLOT_W-1:0]         digit_slot,
	output logic                                last
);
	import avss_pkg::*;

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	logic            push;
	frame_set_t      push_data;
	logic            pop;
	frame_set_t      head;
	logic            q_valid;
	logic [CW-1:0]   q_count;

	avss_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.sample    (sample),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.q_count   (q_count),
		.busy      (busy),
		.push      (push),
		.push_data (push_data)
	);

	avss_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.head      (head),
		.not_empty (q_valid),
		.count     (q_count)
	);

	avss_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.head        (head),
		.pop         (pop),
		.strobe      (strobe),
		.serial_bit  (serial_bit),
		.latch_after (latch_after),
		.digit_slot  (digit_slot),
		.last        (last)
	);

endmodule

@@ bench/avss_bit_checker.sv @@
`timescale 1ns / 100ps
// checker for the voltage readout shifter: predicts the 64 serial bits of every item
// and compares each strobed bit with the oldest one due; depends on avss_pkg only
module avss_bit_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic                            busy,
	input  logic [avss_pkg::SAMPLE_W-1:0]   sample,
	input  logic                            cfg_we,
	input  logic [avss_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [avss_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            strobe,
	input  logic                            serial_bit,
	input  logic                            latch_after,
	input  logic [avss_pkg::SLOT_W-1:0]     digit_slot,
	input  logic                            last,
	output int                              errors,
	output int                              pending,
	output int                              items_taken,
	output int                              bits_checked,
	output int                              clipped
);
	import avss_pkg::*;

	typedef struct packed {
		logic              data;
		logic              latch;
		logic [SLOT_W-1:0] slot;
		logic              fin;
	} shift_bit_t;

	localparam logic [SEG_W-1:0] DIGIT_SEGS [10] = '{
		8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
	};

	shift_bit_t       bit_queue [$];
	logic [SCALE_W-1:0] scale_q  = SCALE_RESET;
	logic [SEG_W-1:0]   sep_q    = SEP_RESET;
	int fail_count = 0;
	int pending_q  = 0;
	int items_q    = 0;
	int bits_q     = 0;
	int clipped_q  = 0;

	assign errors       = fail_count;
	assign pending      = pending_q;
	assign items_taken  = items_q;
	assign bits_checked = bits_q;
	assign clipped      = clipped_q;

	task automatic report_mismatch(input string what, input int got, input int want);
		fail_count++;
		$display("%0t: bit %0d %s got %0h expected %0h", $time, bits_q, what, got, want);
	endtask

	// segment and select frames for one sample under the current registers
	function automatic logic [DIGIT_COUNT-1:0][FRAME_BITS-1:0] display_frames(
		input logic [SAMPLE_W-1:0] s, output bit sat);
		logic [PROD_W-1:0] prod;
		logic [RAW_W-1:0] raw;
		logic [VALUE_W-1:0] v;
		logic [DIGIT_COUNT-1:0][FRAME_BITS-1:0] frames;
		prod = PROD_W'(s) * PROD_W'(scale_q);
		raw = prod[PROD_W-1 -: RAW_W];
		sat = raw > RAW_W'(VALUE_MAX);
		v = sat ? VALUE_MAX : VALUE_W'(raw);
		frames[0] = {DIGIT_SEGS[v / 100], SELECT_FIRST};
		frames[1] = {sep_q, SELECT_FIRST >> 1};
		frames[2] = {DIGIT_SEGS[(v / 10) % 10], SELECT_FIRST >> 2};
		frames[3] = {DIGIT_SEGS[v % 10], SELECT_FIRST >> 3};
		return frames;
	endfunction

	always @(posedge clk) begin
		logic [DIGIT_COUNT-1:0][FRAME_BITS-1:0] frames;
		shift_bit_t b;
		bit sat;
		if (!arst_n) begin
			bit_queue.delete();
			scale_q <= SCALE_RESET;
			sep_q <= SEP_RESET;
			pending_q <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SCALE: scale_q <= cfg_data;
					REG_SEP:   sep_q <= cfg_data[SEG_W-1:0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				frames = display_frames(sample, sat);
				for (int slot = 0; slot < DIGIT_COUNT; slot++) begin
					for (int i = 0; i < FRAME_BITS; i++) begin
						b.data = frames[slot][FRAME_BITS-1-i];
						b.latch = (i == FRAME_BITS - 1);
						b.slot = SLOT_W'(slot);
						b.fin = b.latch && (slot == DIGIT_COUNT - 1);
						bit_queue.push_back(b);
					end
				end
				items_q <= items_q + 1;
				if (sat)
					clipped_q <= clipped_q + 1;
			end
			if (strobe) begin
				if (bit_queue.size() == 0) begin
					report_mismatch("strobe with no item pending", 1, 0);
				end else begin
					b = bit_queue.pop_front();
					if (serial_bit !== b.data)
						report_mismatch("serial_bit", serial_bit, b.data);
					if (latch_after !== b.latch)
						report_mismatch("latch_after", latch_after, b.latch);
					if (digit_slot !== b.slot)
						report_mismatch("digit_slot", digit_slot, b.slot);
					if (last !== b.fin)
						report_mismatch("last", last, b.fin);
				end
				bits_q <= bits_q + 1;
			end
			pending_q <= bit_queue.size();
		end
	end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// top of the voltage readout shifter bench: clock, reset, samples and register writes
// depends on avss_pkg, the block and avss_bit_checker
module tb_top;
	import avss_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_PHASES = 6;
	localparam int PHASE_ITEMS = 33;
	localparam logic [SAMPLE_W-1:0] BASE_SAMPLES [12] = '{
		10'd0, 10'd1, 10'd1023, 10'd512, 10'h155, 10'h2AA,
		10'd100, 10'd205, 10'd307, 10'd409, 10'd614, 10'd921
	};
	localparam logic [SAMPLE_W-1:0] WIDE_SAMPLES [8] = '{
		10'd0, 10'd499, 10'd500, 10'd1023, 10'd9, 10'd90, 10'd123, 10'd987
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [SAMPLE_W-1:0] sample = '0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic busy, strobe, serial_bit, latch_after, last;
	logic [SLOT_W-1:0] digit_slot;

	int errors, pending, items_taken, bits_checked, clipped;
	int settings_used = 0;
	int quiet_cycles = 0;
	bit calm = 1'b0;

	adc_voltage_seven_segment_shifter uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sample(sample),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.strobe(strobe), .serial_bit(serial_bit), .latch_after(latch_after),
		.digit_slot(digit_slot), .last(last)
	);

	avss_bit_checker bit_check (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sample(sample),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.strobe(strobe), .serial_bit(serial_bit), .latch_after(latch_after),
		.digit_slot(digit_slot), .last(last),
		.errors(errors), .pending(pending), .items_taken(items_taken),
		.bits_checked(bits_checked), .clipped(clipped)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// start stays high from one item to the next unless a gap is taken
	task automatic send_sample(input logic [SAMPLE_W-1:0] s);
		if (!calm && $urandom_range(0, 4) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		start <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic drain_and_write(input logic [SCALE_W-1:0] k, input logic [CFG_DATA_W-1:0] sep_word);
		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (6) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_SCALE;
		cfg_data <= k;
		@(posedge clk);
		cfg_index <= REG_SEP;
		cfg_data <= sep_word;
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	initial begin
		logic [SCALE_W-1:0] k;
		logic [SAMPLE_W-1:0] s;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// reset registers first, then full scale with every separator segment lit
		for (int i = 0; i < 12; i++)
			send_sample(BASE_SAMPLES[i]);
		drain_and_write(16'hFFFF, {8'h5A, 8'h00});
		for (int i = 0; i < 8; i++)
			send_sample(WIDE_SAMPLES[i]);
		drain_and_write(16'h0000, {8'hC3, 8'hFF});
		send_sample(10'd1023);
		send_sample(10'd0);
		send_sample(10'h2AA);

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: k = SCALE_RESET;
				1: k = SCALE_W'($urandom_range(0, 65535));
				2: k = 16'hFFFF;
				3: k = SCALE_W'($urandom_range(32000, 65535));
				4: k = SCALE_W'($urandom_range(0, 31999));
				default: k = SCALE_RESET;
			endcase
			drain_and_write(k, CFG_DATA_W'($urandom()));
			calm = (p == RANDOM_PHASES - 1);
			repeat (PHASE_ITEMS) begin
				if ($urandom_range(0, 9) == 0)
					s = $urandom_range(0, 1) ? '1 : '0;
				else
					s = SAMPLE_W'($urandom_range(0, 1023));
				send_sample(s);
			end
		end

		start <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (12) @(posedge clk);
		$display("covered %0d samples, %0d serial bits checked, %0d samples clipped at full scale",
			items_taken, bits_checked, clipped);
		$display("register settings used: %0d after the reset values", settings_used);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// watchdog on cycles where neither side moves anything
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || strobe || cfg_we) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= IDLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule

@@ adc_voltage_seven_segment_shifter.f @@
rtl/avss_pkg.sv
rtl/avss_front.sv
rtl/avss_queue.sv
rtl/avss_back.sv
rtl/adc_voltage_seven_segment_shifter.sv
bench/avss_bit_checker.sv
bench/tb_top.sv
